// File: src/wfpsm_pkg.sv
// wfpsm_pkg: widths, register indexes and reset values of the wall-follow pid speed mixer
// no dependencies; used by the channel interfaces and the top level
package wfpsm_pkg;

	localparam int ProxW   = 12;
	localparam int GainW   = 16;
	localparam int SpeedW  = 10;
	localparam int ThreshW = 15;
	localparam int ErrW    = 13;
	localparam int DiffW   = 14;
	localparam int SumW    = 24;
	localparam int DriveW  = 16;
	localparam int WheelW  = 11;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 16;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_KP_GAIN         = 3'd0,
		REG_KI_GAIN         = 3'd1,
		REG_KD_GAIN         = 3'd2,
		REG_TARGET_DISTANCE = 3'd3,
		REG_CRUISE_SPEED    = 3'd4,
		REG_TURN_THRESHOLD  = 3'd5,
		REG_SPEED_LIMIT     = 3'd6
	} cfg_reg_t;

	// register reset values
	localparam logic [GainW-1:0]   KpReset     = 16'd256;
	localparam logic [GainW-1:0]   KiReset     = 16'd0;
	localparam logic [GainW-1:0]   KdReset     = 16'd0;
	localparam logic [ProxW-1:0]   TargetReset = 12'd0;
	localparam logic [SpeedW-1:0]  CruiseReset = 10'd0;
	localparam logic [ThreshW-1:0] ThreshReset = 15'd200;
	localparam logic [SpeedW-1:0]  LimitReset  = 10'd1000;

endpackage

// File: src/wfpsm_ifs.sv
// wfpsm channel interfaces: proximity request in, drive and wheel speed request out
// depends on wfpsm_pkg for field widths
interface wfpsm_prox_if;
	logic                              valid;
	logic                              ready;
	logic [wfpsm_pkg::ProxW-1:0]       prox_value;

	modport source (output valid, output prox_value, input ready);
	modport sink   (input valid, input prox_value, output ready);
endinterface

interface wfpsm_mix_if;
	logic                              valid;
	logic                              ready;
	logic signed [wfpsm_pkg::DriveW-1:0] drive_value;
	logic signed [wfpsm_pkg::WheelW-1:0] left_speed;
	logic signed [wfpsm_pkg::WheelW-1:0] right_speed;

	modport source (output valid, output drive_value, output left_speed, output right_speed,
		input ready);
	modport sink   (input valid, input drive_value, input left_speed, input right_speed,
		output ready);
endinterface

// File: src/wall_follow_pid_speed_mixer.sv
// wall_follow_pid_speed_mixer: pid drive from a proximity error, mixed into two wheel speeds
// throughput one request per cycle while mix_out.ready does not stall the pipeline
// stages: error and saturating sum, three gain products, drive sum and saturate, wheel mix
// the error state is updated when a request is taken, so back-to-back requests chain exactly
// arst_n clears registers to their reset values, error state to zero and all stage valids
// depends on wfpsm_pkg and wfpsm_ifs
module wall_follow_pid_speed_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	wfpsm_prox_if.sink                        prox_in,
	wfpsm_mix_if.source                       mix_out,
	input  logic                              cfg_we,
	input  logic [wfpsm_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [wfpsm_pkg::CfgDatW-1:0]     cfg_wdata
);

	// configuration registers
	logic signed [wfpsm_pkg::GainW-1:0]   kp_q, ki_q, kd_q;
	logic [wfpsm_pkg::ProxW-1:0]          target_q;
	logic [wfpsm_pkg::SpeedW-1:0]         cruise_q, limit_q;
	logic [wfpsm_pkg::ThreshW-1:0]        thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= wfpsm_pkg::KpReset;
			ki_q     <= wfpsm_pkg::KiReset;
			kd_q     <= wfpsm_pkg::KdReset;
			target_q <= wfpsm_pkg::TargetReset;
			cruise_q <= wfpsm_pkg::CruiseReset;
			thresh_q <= wfpsm_pkg::ThreshReset;
			limit_q  <= wfpsm_pkg::LimitReset;
		end else if (cfg_we) begin
			unique case (wfpsm_pkg::cfg_reg_t'(cfg_index))
				wfpsm_pkg::REG_KP_GAIN:         kp_q     <= cfg_wdata;
				wfpsm_pkg::REG_KI_GAIN:         ki_q     <= cfg_wdata;
				wfpsm_pkg::REG_KD_GAIN:         kd_q     <= cfg_wdata;
				wfpsm_pkg::REG_TARGET_DISTANCE: target_q <= cfg_wdata[wfpsm_pkg::ProxW-1:0];
				wfpsm_pkg::REG_CRUISE_SPEED:    cruise_q <= cfg_wdata[wfpsm_pkg::SpeedW-1:0];
				wfpsm_pkg::REG_TURN_THRESHOLD:  thresh_q <= cfg_wdata[wfpsm_pkg::ThreshW-1:0];
				wfpsm_pkg::REG_SPEED_LIMIT:     limit_q  <= cfg_wdata[wfpsm_pkg::SpeedW-1:0];
				default: ;
			endcase
		end
	end

	// stage handshake: each stage loads when empty or when the next one moves on
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic take;

	assign rdy4 = !v_s4 || mix_out.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign prox_in.ready = rdy1;
	assign take = prox_in.valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= prox_in.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: error, derivative term and saturating error sum
	logic signed [wfpsm_pkg::ErrW-1:0]  last_error_q, err_c, err_s1;
	logic signed [wfpsm_pkg::DiffW-1:0] diff_c, diff_s1;
	logic signed [wfpsm_pkg::SumW-1:0]  error_sum_q, sum_c, sum_s1;
	logic signed [wfpsm_pkg::SumW:0]    sum_wide;

	always_comb begin
		err_c    = $signed({1'b0, prox_in.prox_value}) - $signed({1'b0, target_q});
		diff_c   = $signed({err_c[wfpsm_pkg::ErrW-1], err_c})
			- $signed({last_error_q[wfpsm_pkg::ErrW-1], last_error_q});
		sum_wide = $signed({error_sum_q[wfpsm_pkg::SumW-1], error_sum_q})
			+ $signed({{(wfpsm_pkg::SumW+1-wfpsm_pkg::ErrW){err_c[wfpsm_pkg::ErrW-1]}}, err_c});
		if (sum_wide[wfpsm_pkg::SumW] != sum_wide[wfpsm_pkg::SumW-1]) begin
			sum_c = sum_wide[wfpsm_pkg::SumW]
				? {1'b1, {(wfpsm_pkg::SumW-1){1'b0}}}
				: {1'b0, {(wfpsm_pkg::SumW-1){1'b1}}};
		end else begin
			sum_c = sum_wide[wfpsm_pkg::SumW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else if (take) begin
			last_error_q <= err_c;
			error_sum_q  <= sum_c;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			err_s1  <= err_c;
			diff_s1 <= diff_c;
			sum_s1  <= sum_c;
		end
	end

	// stage 2: the three gain products
	logic signed [28:0] prod_p_s2;
	logic signed [39:0] prod_i_s2;
	logic signed [29:0] prod_d_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			prod_p_s2 <= kp_q * err_s1;
			prod_i_s2 <= ki_q * sum_s1;
			prod_d_s2 <= kd_q * diff_s1;
		end
	end

	// stage 3: sum, floor shift by eight and saturate to the drive width
	logic signed [40:0] acc_c;
	logic signed [32:0] quo_c;
	logic signed [wfpsm_pkg::DriveW-1:0] drive_c, drive_s3;

	always_comb begin
		acc_c = $signed({{12{prod_p_s2[28]}}, prod_p_s2})
			+ $signed({prod_i_s2[39], prod_i_s2})
			+ $signed({{11{prod_d_s2[29]}}, prod_d_s2});
		quo_c = acc_c[40:8];
		if (quo_c[32:15] == {18{1'b0}} || quo_c[32:15] == {18{1'b1}}) begin
			drive_c = quo_c[wfpsm_pkg::DriveW-1:0];
		end else begin
			drive_c = quo_c[32] ? {1'b1, {(wfpsm_pkg::DriveW-1){1'b0}}}
				: {1'b0, {(wfpsm_pkg::DriveW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) drive_s3 <= drive_c;
	end

	// stage 4: base speed choice and clamped wheel mix into the result register
	logic [16:0]                         mag_c;
	logic signed [16:0]                  drive_x;
	logic [wfpsm_pkg::SpeedW-1:0]        base_c;
	logic signed [17:0]                  right_w, left_w, lim_p, lim_n;
	logic signed [wfpsm_pkg::WheelW-1:0] right_c, left_c;
	logic signed [wfpsm_pkg::DriveW-1:0] drive_s4;
	logic signed [wfpsm_pkg::WheelW-1:0] left_s4, right_s4;

	always_comb begin
		drive_x = $signed({drive_s3[wfpsm_pkg::DriveW-1], drive_s3});
		mag_c   = drive_s3[wfpsm_pkg::DriveW-1] ? 17'(-drive_x) : 17'(drive_x);
		base_c  = (mag_c > {2'b00, thresh_q}) ? '0 : cruise_q;
		lim_p   = $signed({8'b0, limit_q});
		lim_n   = -lim_p;
		right_w = $signed({8'b0, base_c}) + $signed({drive_x[16], drive_x});
		left_w  = $signed({8'b0, base_c}) - $signed({drive_x[16], drive_x});
		if (right_w > lim_p)      right_c = lim_p[wfpsm_pkg::WheelW-1:0];
		else if (right_w < lim_n) right_c = lim_n[wfpsm_pkg::WheelW-1:0];
		else                      right_c = right_w[wfpsm_pkg::WheelW-1:0];
		if (left_w > lim_p)       left_c = lim_p[wfpsm_pkg::WheelW-1:0];
		else if (left_w < lim_n)  left_c = lim_n[wfpsm_pkg::WheelW-1:0];
		else                      left_c = left_w[wfpsm_pkg::WheelW-1:0];
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			drive_s4 <= drive_s3;
			left_s4  <= left_c;
			right_s4 <= right_c;
		end
	end

	// result request
	assign mix_out.valid       = v_s4;
	assign mix_out.drive_value = drive_s4;
	assign mix_out.left_speed  = left_s4;
	assign mix_out.right_speed = right_s4;

endmodule

// File: sim/tb_wall_follow_pid_speed_mixer.sv
// tb_wall_follow_pid_speed_mixer: self-checking bench for the wall-follow pid speed mixer
// drives proximity requests and register writes, predicts drive and wheel speeds per request
// depends on wfpsm_pkg, wfpsm_ifs and the wall_follow_pid_speed_mixer rtl
`timescale 1ns / 1ps

module tb_wall_follow_pid_speed_mixer;

	// field widths taken from the package
	localparam int ProxW   = wfpsm_pkg::ProxW;
	localparam int GainW   = wfpsm_pkg::GainW;
	localparam int SpeedW  = wfpsm_pkg::SpeedW;
	localparam int ThreshW = wfpsm_pkg::ThreshW;
	localparam int ErrW    = wfpsm_pkg::ErrW;
	localparam int SumW    = wfpsm_pkg::SumW;
	localparam int DriveW  = wfpsm_pkg::DriveW;
	localparam int WheelW  = wfpsm_pkg::WheelW;
	localparam int CfgIdxW = wfpsm_pkg::CfgIdxW;
	localparam int CfgDatW = wfpsm_pkg::CfgDatW;

	localparam int     StallLimit = 1000;
	localparam int     HoldCycles = 80;
	localparam int     MaxReports = 10;
	localparam longint SumMax     = (longint'(1) <<< (SumW - 1)) - 1;
	localparam longint SumMin     = -(longint'(1) <<< (SumW - 1));
	localparam longint DriveMax   = (longint'(1) <<< (DriveW - 1)) - 1;
	localparam longint DriveMin   = -(longint'(1) <<< (DriveW - 1));
	// index that maps to no register
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

	typedef struct packed {
		logic signed [DriveW-1:0] drive;
		logic signed [WheelW-1:0] left;
		logic signed [WheelW-1:0] right;
	} mix_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDatW-1:0]  cfg_wdata;

	wfpsm_prox_if prox_ch ();
	wfpsm_mix_if  mix_ch ();

	wall_follow_pid_speed_mixer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.prox_in   (prox_ch),
		.mix_out   (mix_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor copy of the registers and the error state
	logic signed [GainW-1:0] gain_p, gain_i, gain_d;
	logic [ProxW-1:0]        set_point;
	logic [SpeedW-1:0]       cruise, wheel_limit;
	logic [ThreshW-1:0]      turn_thresh;
	logic signed [ErrW-1:0]  last_err;
	logic signed [SumW-1:0]  err_sum;

	mix_t pending_mix[$];
	int   mix_errors;
	bit   no_idle;
	bit   hold_req;
	int   hold_left;
	int   quiet_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// one pid tick: updates the error state and returns drive and wheel speeds
	function automatic mix_t pid_mix_step(input logic [ProxW-1:0] prox);
		longint err, diff, sum, acc, drv, mag, base, lim;
		mix_t   r;
		err  = longint'(prox) - longint'(set_point);
		diff = err - longint'(last_err);
		sum  = clip(longint'(err_sum) + err, SumMin, SumMax);
		acc  = longint'(gain_p) * err + longint'(gain_i) * sum + longint'(gain_d) * diff;
		// arithmetic shift gives floor rounding
		drv  = clip(acc >>> 8, DriveMin, DriveMax);
		err_sum  = sum[SumW-1:0];
		last_err = err[ErrW-1:0];
		mag  = (drv < 0) ? -drv : drv;
		base = (mag > longint'(turn_thresh)) ? 0 : longint'(cruise);
		lim  = longint'(wheel_limit);
		r.drive = drv[DriveW-1:0];
		r.right = WheelW'(clip(base + drv, -lim, lim));
		r.left  = WheelW'(clip(base - drv, -lim, lim));
		return r;
	endfunction

	// write data with junk above the register width
	function automatic logic [CfgDatW-1:0] pad(input logic [CfgDatW-1:0] v, input int w);
		logic [CfgDatW-1:0] mask;
		mask = (w >= CfgDatW) ? '1 : ((CfgDatW'(1) << w) - 1'b1);
		return (CfgDatW'($urandom) & ~mask) | (v & mask);
	endfunction

	// register write, mirrored into the predictor at the accepting edge
	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			wfpsm_pkg::REG_KP_GAIN:         gain_p      = data[GainW-1:0];
			wfpsm_pkg::REG_KI_GAIN:         gain_i      = data[GainW-1:0];
			wfpsm_pkg::REG_KD_GAIN:         gain_d      = data[GainW-1:0];
			wfpsm_pkg::REG_TARGET_DISTANCE: set_point   = data[ProxW-1:0];
			wfpsm_pkg::REG_CRUISE_SPEED:    cruise      = data[SpeedW-1:0];
			wfpsm_pkg::REG_TURN_THRESHOLD:  turn_thresh = data[ThreshW-1:0];
			wfpsm_pkg::REG_SPEED_LIMIT:     wheel_limit = data[SpeedW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we    <= 1'b0;
		cfg_wdata <= CfgDatW'($urandom);
	endtask

	task automatic set_regs(input logic [GainW-1:0] kp, input logic [GainW-1:0] ki,
		input logic [GainW-1:0] kd, input logic [ProxW-1:0] tgt,
		input logic [SpeedW-1:0] crs, input logic [ThreshW-1:0] thr,
		input logic [SpeedW-1:0] lim);
		cfg_write(wfpsm_pkg::REG_KP_GAIN, kp);
		cfg_write(wfpsm_pkg::REG_KI_GAIN, ki);
		cfg_write(wfpsm_pkg::REG_KD_GAIN, kd);
		cfg_write(wfpsm_pkg::REG_TARGET_DISTANCE, pad(tgt, ProxW));
		cfg_write(wfpsm_pkg::REG_CRUISE_SPEED, pad(crs, SpeedW));
		cfg_write(wfpsm_pkg::REG_TURN_THRESHOLD, pad(thr, ThreshW));
		cfg_write(wfpsm_pkg::REG_SPEED_LIMIT, pad(lim, SpeedW));
	endtask

	// offer one proximity request, with random gaps, and predict its result on acceptance
	task automatic send_prox(input logic [ProxW-1:0] v);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 16) begin
			prox_ch.valid      <= 1'b0;
			prox_ch.prox_value <= ProxW'($urandom);
			@(negedge clk);
		end
		prox_ch.valid      <= 1'b1;
		prox_ch.prox_value <= v;
		@(posedge clk);
		while (!prox_ch.ready) @(posedge clk);
		pending_mix.push_back(pid_mix_step(v));
	endtask

	// stop offering and wait for every expected result
	task automatic wait_drain();
		@(negedge clk);
		prox_ch.valid <= 1'b0;
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// reset values, full input range with unit proportional gain
	task automatic test_reset_values();
		send_prox(12'd0);
		send_prox(12'd4095);
		send_prox(12'd1);
		send_prox(12'd2048);
		send_prox(12'd200);
		send_prox(12'd201);
		send_prox(12'd4094);
		wait_drain();
	endtask

	// floor rounding of the scaled sum with a half gain and a negative gain
	task automatic test_rounding();
		set_regs(16'h0080, 16'h0000, 16'h0000, 12'd100, 10'd0, 15'd32767, 10'd1000);
		send_prox(12'd101);
		send_prox(12'd99);
		send_prox(12'd103);
		send_prox(12'd97);
		wait_drain();
		cfg_write(wfpsm_pkg::REG_KP_GAIN, 16'hFFFF);
		send_prox(12'd101);
		send_prox(12'd99);
		wait_drain();
	endtask

	// base speed on both sides of the turn threshold
	task automatic test_turn_threshold();
		set_regs(16'h0100, 16'h0000, 16'h0000, 12'd2000, 10'd700, 15'd100, 10'd1023);
		send_prox(12'd2100);
		send_prox(12'd2101);
		send_prox(12'd1900);
		send_prox(12'd1899);
		send_prox(12'd2000);
		wait_drain();
	endtask

	// drive saturation, derivative swings and wheel clamps at both limits
	task automatic test_wheel_clamp();
		set_regs(16'h7FFF, 16'h0000, 16'h8000, 12'd0, 10'd1023, 15'd0, 10'd1023);
		send_prox(12'd4095);
		send_prox(12'd0);
		send_prox(12'd4095);
		wait_drain();
		cfg_write(wfpsm_pkg::REG_TARGET_DISTANCE, pad(12'd4095, ProxW));
		cfg_write(wfpsm_pkg::REG_SPEED_LIMIT, pad(10'd0, SpeedW));
		send_prox(12'd0);
		send_prox(12'd4095);
		wait_drain();
	endtask

	// write to the spare index must leave every register alone
	task automatic test_unused_index();
		set_regs(16'h0100, 16'h0000, 16'h0000, 12'd1000, 10'd300, 15'd500, 10'd800);
		cfg_write(RegUnused, CfgDatW'($urandom));
		cfg_write(RegUnused, 16'hFFFF);
		send_prox(12'd1200);
		send_prox(12'd1600);
		wait_drain();
	endtask

	// integral term: run the error sum down then back up, first with no idling at all
	task automatic test_integral_sum();
		no_idle = 1'b1;
		set_regs(16'h0000, 16'h0001, 16'h0000, 12'd4095, 10'd500, 15'd32767, 10'd1023);
		for (int n = 0; n < 40; n++) send_prox(12'd0);
		wait_drain();
		no_idle = 1'b0;
		cfg_write(wfpsm_pkg::REG_TARGET_DISTANCE, pad(12'd0, ProxW));
		for (int n = 0; n < 20; n++) send_prox(12'd4095);
		wait_drain();
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_back_pressure();
		set_regs(16'h0040, 16'h0000, 16'h0100, 12'd1500, 10'd400, 15'd300, 10'd900);
		@(posedge clk);
		hold_req = 1'b1;
		for (int n = 0; n < 40; n++) send_prox(ProxW'($urandom));
		wait_drain();
	endtask

	// random requests under extreme and random register settings
	task automatic test_random();
		logic [ProxW-1:0] p;
		int               sel;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_regs(GainW'($urandom_range(2048) - 1024), GainW'($urandom_range(32) - 16),
					GainW'($urandom_range(1024) - 512), ProxW'($urandom),
					SpeedW'($urandom), ThreshW'($urandom_range(2000)), SpeedW'($urandom));
				1: set_regs(16'h7FFF, 16'h8000, 16'h7FFF, 12'd4095, 10'd1023, 15'd32767, 10'd1023);
				2: set_regs(16'h8000, 16'h0000, 16'h8000, 12'd0, 10'd0, 15'd0, 10'd0);
				3: set_regs(GainW'($urandom_range(512) - 256), 16'h0000,
					GainW'($urandom_range(512) - 256), ProxW'($urandom_range(4095)),
					SpeedW'($urandom_range(1000)), ThreshW'($urandom_range(600)),
					SpeedW'($urandom_range(1000)));
				default: set_regs(GainW'($urandom), GainW'($urandom), GainW'($urandom),
					ProxW'($urandom), SpeedW'($urandom), ThreshW'($urandom), SpeedW'($urandom));
			endcase
			for (int n = 0; n < 75; n++) begin
				sel = $urandom_range(99);
				// half near the set point, some anywhere, some at the ends of the range
				if (sel < 50)
					p = ProxW'(clip(longint'(set_point) + $urandom_range(128) - 64, 0, 4095));
				else if (sel < 80)
					p = ProxW'($urandom);
				else
					p = $urandom_range(1) ? 12'd4095 : 12'd0;
				send_prox(p);
			end
			wait_drain();
		end
	endtask

	// receiver: random stalls, or a held-off stretch when asked
	initial begin
		mix_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HoldCycles;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				mix_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				mix_ch.ready <= no_idle || ($urandom_range(99) >= 16);
			end
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		mix_t exp_mix;
		if (arst_n && mix_ch.valid && mix_ch.ready) begin
			if (pending_mix.size() == 0) begin
				if (mix_errors < MaxReports)
					$display("%0t: unexpected result drive %0d left %0d right %0d", $time,
						mix_ch.drive_value, mix_ch.left_speed, mix_ch.right_speed);
				mix_errors++;
			end else begin
				exp_mix = pending_mix.pop_front();
				if (mix_ch.drive_value !== exp_mix.drive || mix_ch.left_speed !== exp_mix.left ||
					mix_ch.right_speed !== exp_mix.right) begin
					if (mix_errors < MaxReports)
						$display("%0t: mismatch exp drive %0d left %0d right %0d, got %0d %0d %0d",
							$time, exp_mix.drive, exp_mix.left, exp_mix.right,
							mix_ch.drive_value, mix_ch.left_speed, mix_ch.right_speed);
					mix_errors++;
				end
			end
		end
	end

	// watchdog on cycles with no request accepted on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((prox_ch.valid && prox_ch.ready) || (mix_ch.valid && mix_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("FAIL wall_follow_pid_speed_mixer");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = wfpsm_pkg::REG_KP_GAIN;
		cfg_wdata          = '0;
		prox_ch.valid      = 1'b0;
		prox_ch.prox_value = '0;
		no_idle            = 1'b0;
		hold_req           = 1'b0;
		mix_errors         = 0;
		quiet_cycles       = 0;
		gain_p             = wfpsm_pkg::KpReset;
		gain_i             = wfpsm_pkg::KiReset;
		gain_d             = wfpsm_pkg::KdReset;
		set_point          = wfpsm_pkg::TargetReset;
		cruise             = wfpsm_pkg::CruiseReset;
		turn_thresh        = wfpsm_pkg::ThreshReset;
		wheel_limit        = wfpsm_pkg::LimitReset;
		last_err           = '0;
		err_sum            = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_rounding();
		test_turn_threshold();
		test_wheel_clamp();
		test_unused_index();
		test_integral_sum();
		test_back_pressure();
		test_random();
		wait_drain();

		if (mix_errors == 0 && pending_mix.size() == 0)
			$display("PASS wall_follow_pid_speed_mixer");
		else
			$display("FAIL wall_follow_pid_speed_mixer");
		$finish;
	end

endmodule
